/* rtl/bvp_pkg.sv */
`default_nettype none

package bvp_pkg;

  // Number format and derived widths
  localparam int FRAC_BITS = 16;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int WIDE_W    = PROD_W + 2;

  // Square root: one result bit per stage over a product-wide radicand
  localparam int SQ_STEPS  = PROD_W / 2;
  localparam int GAM_W     = PROD_W / 2;

  // Divide by gamma: one quotient bit per stage
  localparam int RQ_STEPS  = WORD_W;

  // Divide by the rotation denominator: one quotient bit per stage
  localparam int DQ_STEPS  = PROD_W - FRAC_BITS;
  localparam int DEN_W     = PROD_W - FRAC_BITS;

  // Register stages from input register to output register
  localparam int NUM_STAGES = 14 + SQ_STEPS + RQ_STEPS + DQ_STEPS;

  localparam int CFG_IDX_W = 3;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef word_t [2:0] vec_t;
  typedef prod_t [2:0] pvec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORCE_NORM = 3'd0,
    REG_STEP_NORM  = 3'd1,
    REG_HALF_STEP  = 3'd2,
    REG_SWAP_AXES  = 3'd3,
    REG_RELATIVIST = 3'd4
  } cfg_idx_t;

  // Values that ride along with a request through the long stages
  typedef struct packed {
    vec_t u;
    vec_t vm;
    vec_t b;
    logic clip;
  } carry_t;

  localparam logic [PROD_W-1:0] ONE_P = {{(PROD_W-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // Cyclic neighbors for the cross products
  localparam int NXT [3] = '{1, 2, 0};
  localparam int PRV [3] = '{2, 0, 1};

  // Clip to the signed word range
  function automatic word_t sat_val(input wide_t x);
    word_t r;
    if (x > wide_t'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (x < wide_t'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = x[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic sat_clip(input wide_t x);
    return (x > wide_t'(WORD_MAX)) || (x < wide_t'(WORD_MIN));
  endfunction

endpackage

`default_nettype wire

/* rtl/boris_velocity_push_unit.sv */
`default_nettype none

// Boris momentum pusher. One particle (old momentum, E and B, signed Q16.16) is
// taken per clock and its new momentum with a saturation flag comes out of the
// output register; throughput is one particle per cycle while results are
// taken, and when a result is not taken, the whole pipeline holds. The stages
// include a 32-stage bitwise square root for gamma, a 32-stage long division of
// b by gamma and a 48-stage long division by the rotation denominator, each one
// bit per stage and present in either relativistic setting. Registers are to be
// written only while no particle is in flight; the block does not enforce it.
module boris_velocity_push_unit
  import bvp_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire  signed [31:0]   in_old_mom_0,
  input  wire  signed [31:0]   in_old_mom_1,
  input  wire  signed [31:0]   in_old_mom_2,
  input  wire  signed [31:0]   in_efield_0,
  input  wire  signed [31:0]   in_efield_1,
  input  wire  signed [31:0]   in_efield_2,
  input  wire  signed [31:0]   in_bfield_0,
  input  wire  signed [31:0]   in_bfield_1,
  input  wire  signed [31:0]   in_bfield_2,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic signed [31:0]   out_new_mom_0,
  output logic signed [31:0]   out_new_mom_1,
  output logic signed [31:0]   out_new_mom_2,
  output logic                 out_saturated,
  input  wire                  cfg_we,
  input  wire  [CFG_IDX_W-1:0] cfg_index,
  input  wire  [31:0]          cfg_wdata
);

  localparam int ST_SQ0 = 5;
  localparam int ST_RD0 = ST_SQ0 + SQ_STEPS + 1;
  localparam int ST_BF  = ST_RD0 + RQ_STEPS + 1;
  localparam int ST_F   = ST_BF + 1;
  localparam int ST_G   = ST_F + 1;
  localparam int ST_H   = ST_G + 1;
  localparam int ST_DV0 = ST_H + 1;
  localparam int ST_J   = ST_DV0 + DQ_STEPS + 1;
  localparam int ST_K   = ST_J + 1;

  // Configuration registers
  word_t cfg_force_norm_r;
  word_t cfg_step_norm_r;
  logic  cfg_half_step_r;
  logic  cfg_swap_r;
  logic  cfg_rel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_force_norm_r <= word_t'(ONE_P);
      cfg_step_norm_r  <= '0;
      cfg_half_step_r  <= 1'b1;
      cfg_swap_r       <= 1'b0;
      cfg_rel_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_FORCE_NORM: cfg_force_norm_r <= cfg_wdata;
        REG_STEP_NORM:  cfg_step_norm_r  <= cfg_wdata;
        REG_HALF_STEP:  cfg_half_step_r  <= cfg_wdata[0];
        REG_SWAP_AXES:  cfg_swap_r       <= cfg_wdata[0];
        REG_RELATIVIST: cfg_rel_r        <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pipeline control: all stages advance together unless the result is held
  logic                  adv;
  logic [NUM_STAGES-1:0] vld_r;

  assign adv       = !vld_r[ST_K] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld_r[ST_K];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NUM_STAGES-2:0], in_valid};
    end
  end

  // Stage 1: capture request with axis swap, form force_norm * step_norm
  vec_t  s1_u_r, s1_e_r, s1_b_r;
  prod_t s1_fs_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_u_r[0] <= in_old_mom_0;
      s1_u_r[1] <= cfg_swap_r ? in_old_mom_2 : in_old_mom_1;
      s1_u_r[2] <= cfg_swap_r ? in_old_mom_1 : in_old_mom_2;
      s1_e_r[0] <= in_efield_0;
      s1_e_r[1] <= cfg_swap_r ? in_efield_2 : in_efield_1;
      s1_e_r[2] <= cfg_swap_r ? in_efield_1 : in_efield_2;
      s1_b_r[0] <= in_bfield_0;
      s1_b_r[1] <= cfg_swap_r ? in_bfield_2 : in_bfield_1;
      s1_b_r[2] <= cfg_swap_r ? in_bfield_1 : in_bfield_2;
      s1_fs_r   <= cfg_force_norm_r * cfg_step_norm_r;
    end
  end

  // Stage 2: alpha = half the product, clipped
  vec_t  s2_u_r, s2_e_r, s2_b_r;
  word_t s2_alpha_r;
  logic  s2_clip_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_u_r     <= s1_u_r;
      s2_e_r     <= s1_e_r;
      s2_b_r     <= s1_b_r;
      s2_alpha_r <= sat_val(wide_t'(s1_fs_r >>> (FRAC_BITS + 1)));
      s2_clip_r  <= sat_clip(wide_t'(s1_fs_r >>> (FRAC_BITS + 1)));
    end
  end

  // Stage 3: alpha * E and alpha * B
  vec_t  s3_u_r;
  pvec_t s3_pe_r, s3_pb_r;
  logic  s3_clip_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_u_r    <= s2_u_r;
      s3_clip_r <= s2_clip_r;
      for (int k = 0; k < 3; k++) begin
        s3_pe_r[k] <= s2_alpha_r * s2_e_r[k];
        s3_pb_r[k] <= s2_alpha_r * s2_b_r[k];
      end
    end
  end

  // Stage 4: half kick and scaled field
  vec_t s4_ae;
  vec_t s4_vm_nxt, s4_b_nxt;
  logic s4_clip_nxt;
  vec_t s4_u_r, s4_vm_r, s4_b_r;
  logic s4_clip_r;

  always_comb begin
    s4_clip_nxt = s3_clip_r;
    for (int k = 0; k < 3; k++) begin
      s4_ae[k]     = sat_val(wide_t'(s3_pe_r[k] >>> FRAC_BITS));
      s4_vm_nxt[k] = sat_val(wide_t'(s3_u_r[k]) + wide_t'(s4_ae[k]));
      s4_b_nxt[k]  = sat_val(wide_t'(s3_pb_r[k] >>> FRAC_BITS));
      s4_clip_nxt  = s4_clip_nxt
                   | sat_clip(wide_t'(s3_pe_r[k] >>> FRAC_BITS))
                   | sat_clip(wide_t'(s3_u_r[k]) + wide_t'(s4_ae[k]))
                   | sat_clip(wide_t'(s3_pb_r[k] >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_u_r    <= s3_u_r;
      s4_vm_r   <= s4_vm_nxt;
      s4_b_r    <= s4_b_nxt;
      s4_clip_r <= s4_clip_nxt;
    end
  end

  // Stage 5: squares of the half-kicked momentum
  pvec_t  s5_sq_r;
  carry_t s5_c_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s5_sq_r[k] <= s4_vm_r[k] * s4_vm_r[k];
      end
      s5_c_r <= '{u: s4_u_r, vm: s4_vm_r, b: s4_b_r, clip: s4_clip_r};
    end
  end

  // Square root of (1 + |vm|^2) scaled, one result bit per stage
  logic [PROD_W-1:0] sq_x_r   [SQ_STEPS+1];
  logic [PROD_W-1:0] sq_res_r [SQ_STEPS+1];
  carry_t            sq_c_r   [SQ_STEPS+1];
  logic [PROD_W-1:0] sq_g2_nxt;

  always_comb begin
    sq_g2_nxt = ONE_P;
    for (int k = 0; k < 3; k++) begin
      sq_g2_nxt = sq_g2_nxt + (s5_sq_r[k] >>> FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x_r[0]   <= sq_g2_nxt << FRAC_BITS;
      sq_res_r[0] <= '0;
      sq_c_r[0]   <= s5_c_r;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    localparam logic [PROD_W-1:0] SQ_BIT =
      {{(PROD_W-1){1'b0}}, 1'b1} << (PROD_W - 2 - 2 * i);
    logic [PROD_W-1:0] trial;
    logic              take;

    always_comb begin
      trial = sq_res_r[i] + SQ_BIT;
      take  = sq_x_r[i] >= trial;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x_r[i+1]   <= take ? sq_x_r[i] - trial : sq_x_r[i];
        sq_res_r[i+1] <= take ? (sq_res_r[i] >> 1) + SQ_BIT : sq_res_r[i] >> 1;
        sq_c_r[i+1]   <= sq_c_r[i];
      end
    end
  end

  // Divide b by gamma; gamma is one when not relativistic, which keeps b
  logic [GAM_W-1:0]  rd_gam_r [RQ_STEPS+1];
  logic [GAM_W-1:0]  rd_rem_r [RQ_STEPS+1][3];
  logic [WORD_W-1:0] rd_num_r [RQ_STEPS+1][3];
  logic [WORD_W-1:0] rd_q_r   [RQ_STEPS+1][3];
  logic [2:0]        rd_neg_r [RQ_STEPS+1];
  carry_t            rd_c_r   [RQ_STEPS+1];
  logic [WORD_W-1:0] rd_mag [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_mag[k] = sq_c_r[SQ_STEPS].b[k][WORD_W-1] ?
                  WORD_W'(-sq_c_r[SQ_STEPS].b[k]) : WORD_W'(sq_c_r[SQ_STEPS].b[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd_gam_r[0] <= cfg_rel_r ? sq_res_r[SQ_STEPS][GAM_W-1:0] : GAM_W'(ONE_P);
      rd_c_r[0]   <= sq_c_r[SQ_STEPS];
      for (int k = 0; k < 3; k++) begin
        rd_neg_r[0][k] <= sq_c_r[SQ_STEPS].b[k][WORD_W-1];
        rd_rem_r[0][k] <= GAM_W'(rd_mag[k][WORD_W-1 -: FRAC_BITS]);
        rd_num_r[0][k] <= {rd_mag[k][WORD_W-1-FRAC_BITS:0], {FRAC_BITS{1'b0}}};
        rd_q_r[0][k]   <= '0;
      end
    end
  end

  for (genvar i = 0; i < RQ_STEPS; i++) begin : g_rdiv
    logic [GAM_W:0] trial [3];
    logic [2:0]     take;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {rd_rem_r[i][k], rd_num_r[i][k][WORD_W-1]};
        take[k]  = trial[k] >= {1'b0, rd_gam_r[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rd_gam_r[i+1] <= rd_gam_r[i];
        rd_neg_r[i+1] <= rd_neg_r[i];
        rd_c_r[i+1]   <= rd_c_r[i];
        for (int k = 0; k < 3; k++) begin
          rd_rem_r[i+1][k] <= take[k] ? GAM_W'(trial[k] - {1'b0, rd_gam_r[i]})
                                      : trial[k][GAM_W-1:0];
          rd_num_r[i+1][k] <= rd_num_r[i][k] << 1;
          rd_q_r[i+1][k]   <= {rd_q_r[i][k][WORD_W-2:0], take[k]};
        end
      end
    end
  end

  // Restore the sign of the divided field
  carry_t bf_c_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      bf_c_r.u    <= rd_c_r[RQ_STEPS].u;
      bf_c_r.vm   <= rd_c_r[RQ_STEPS].vm;
      bf_c_r.clip <= rd_c_r[RQ_STEPS].clip;
      for (int k = 0; k < 3; k++) begin
        bf_c_r.b[k] <= rd_neg_r[RQ_STEPS][k] ? word_t'(-rd_q_r[RQ_STEPS][k])
                                             : word_t'(rd_q_r[RQ_STEPS][k]);
      end
    end
  end

  // Stage F: |b|^2 terms and first cross products
  pvec_t  f_bb_r, f_x1_r, f_x2_r;
  carry_t f_c_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f_c_r <= bf_c_r;
      for (int k = 0; k < 3; k++) begin
        f_bb_r[k] <= bf_c_r.b[k] * bf_c_r.b[k];
        f_x1_r[k] <= bf_c_r.vm[NXT[k]] * bf_c_r.b[PRV[k]];
        f_x2_r[k] <= bf_c_r.vm[PRV[k]] * bf_c_r.b[NXT[k]];
      end
    end
  end

  // Stage G: rotation denominator and vm + vm x b
  logic [PROD_W-1:0] g_den_nxt;
  wide_t             g_sum [3];
  vec_t              g_vpr_nxt;
  logic              g_clip_nxt;
  logic [DEN_W-1:0]  g_den_r;
  vec_t              g_vpr_r;
  carry_t            g_c_r;

  always_comb begin
    g_den_nxt  = ONE_P;
    g_clip_nxt = f_c_r.clip;
    for (int k = 0; k < 3; k++) begin
      g_den_nxt    = g_den_nxt + (f_bb_r[k] >>> FRAC_BITS);
      g_sum[k]     = wide_t'(f_c_r.vm[k])
                   + ((wide_t'(f_x1_r[k]) - wide_t'(f_x2_r[k])) >>> FRAC_BITS);
      g_vpr_nxt[k] = sat_val(g_sum[k]);
      g_clip_nxt   = g_clip_nxt | sat_clip(g_sum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g_den_r    <= g_den_nxt[DEN_W-1:0];
      g_vpr_r    <= g_vpr_nxt;
      g_c_r.u    <= f_c_r.u;
      g_c_r.vm   <= f_c_r.vm;
      g_c_r.b    <= f_c_r.b;
      g_c_r.clip <= g_clip_nxt;
    end
  end

  // Stage H: second cross products
  pvec_t            h_y1_r, h_y2_r;
  logic [DEN_W-1:0] h_den_r;
  carry_t           h_c_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      h_den_r <= g_den_r;
      h_c_r   <= g_c_r;
      for (int k = 0; k < 3; k++) begin
        h_y1_r[k] <= g_vpr_r[NXT[k]] * g_c_r.b[PRV[k]];
        h_y2_r[k] <= g_vpr_r[PRV[k]] * g_c_r.b[NXT[k]];
      end
    end
  end

  // Long division of (vpr x b) by the denominator, one quotient bit per stage
  logic [DEN_W-1:0]    dv_den_r [DQ_STEPS+1];
  logic [DEN_W-1:0]    dv_rem_r [DQ_STEPS+1][3];
  logic [DQ_STEPS-1:0] dv_num_r [DQ_STEPS+1][3];
  logic [DQ_STEPS-1:0] dv_q_r   [DQ_STEPS+1][3];
  logic [2:0]          dv_neg_r [DQ_STEPS+1];
  carry_t              dv_c_r   [DQ_STEPS+1];
  wide_t               dv_diff [3];
  logic [PROD_W-1:0]   dv_mag  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dv_diff[k] = wide_t'(h_y1_r[k]) - wide_t'(h_y2_r[k]);
      dv_mag[k]  = dv_diff[k][WIDE_W-1] ? PROD_W'(-dv_diff[k]) : PROD_W'(dv_diff[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_den_r[0] <= h_den_r;
      dv_c_r[0]   <= h_c_r;
      for (int k = 0; k < 3; k++) begin
        dv_neg_r[0][k] <= dv_diff[k][WIDE_W-1];
        dv_rem_r[0][k] <= DEN_W'(dv_mag[k][PROD_W-1 -: FRAC_BITS]);
        dv_num_r[0][k] <= dv_mag[k][DQ_STEPS-1:0];
        dv_q_r[0][k]   <= '0;
      end
    end
  end

  for (genvar i = 0; i < DQ_STEPS; i++) begin : g_div
    logic [DEN_W:0] trial [3];
    logic [2:0]     take;

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        trial[k] = {dv_rem_r[i][k], dv_num_r[i][k][DQ_STEPS-1]};
        take[k]  = trial[k] >= {1'b0, dv_den_r[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_den_r[i+1] <= dv_den_r[i];
        dv_neg_r[i+1] <= dv_neg_r[i];
        dv_c_r[i+1]   <= dv_c_r[i];
        for (int k = 0; k < 3; k++) begin
          dv_rem_r[i+1][k] <= take[k] ? DEN_W'(trial[k] - {1'b0, dv_den_r[i]})
                                      : trial[k][DEN_W-1:0];
          dv_num_r[i+1][k] <= dv_num_r[i][k] << 1;
          dv_q_r[i+1][k]   <= {dv_q_r[i][k][DQ_STEPS-2:0], take[k]};
        end
      end
    end
  end

  // Stage J: up = vm + signed quotient
  wide_t j_qw  [3];
  wide_t j_sum [3];
  vec_t  j_up_nxt;
  logic  j_clip_nxt;
  vec_t  j_up_r, j_u_r;
  logic  j_clip_r;

  always_comb begin
    j_clip_nxt = dv_c_r[DQ_STEPS].clip;
    for (int k = 0; k < 3; k++) begin
      j_qw[k]     = wide_t'(dv_q_r[DQ_STEPS][k]);
      j_sum[k]    = wide_t'(dv_c_r[DQ_STEPS].vm[k])
                  + (dv_neg_r[DQ_STEPS][k] ? -j_qw[k] : j_qw[k]);
      j_up_nxt[k] = sat_val(j_sum[k]);
      j_clip_nxt  = j_clip_nxt | sat_clip(j_sum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_up_r   <= j_up_nxt;
      j_u_r    <= dv_c_r[DQ_STEPS].u;
      j_clip_r <= j_clip_nxt;
    end
  end

  // Stage K: optional full step, swap back, output register
  wide_t k_full [3];
  vec_t  k_new;
  logic  k_clip_nxt;
  word_t out_mom0_r, out_mom1_r, out_mom2_r;
  logic  out_sat_r;

  always_comb begin
    k_clip_nxt = j_clip_r;
    for (int k = 0; k < 3; k++) begin
      k_full[k] = (wide_t'(j_up_r[k]) <<< 1) - wide_t'(j_u_r[k]);
      k_new[k]  = cfg_half_step_r ? j_up_r[k] : sat_val(k_full[k]);
      k_clip_nxt = k_clip_nxt | (!cfg_half_step_r && sat_clip(k_full[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mom0_r <= k_new[0];
      out_mom1_r <= cfg_swap_r ? k_new[2] : k_new[1];
      out_mom2_r <= cfg_swap_r ? k_new[1] : k_new[2];
      out_sat_r  <= k_clip_nxt;
    end
  end

  assign out_new_mom_0 = out_mom0_r;
  assign out_new_mom_1 = out_mom1_r;
  assign out_new_mom_2 = out_mom2_r;
  assign out_saturated = out_sat_r;

  // Checks
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> vld_r == '0)
    else $error("pipeline valid bits not cleared by reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_K] && !out_ready) |=> $stable(vld_r))
    else $error("pipeline moved while result was held");

  a_gamma_ge_one: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_RD0] |-> rd_gam_r[0] >= GAM_W'(ONE_P))
    else $error("gamma below one");

  a_denom_ge_one: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_H] |-> h_den_r >= DEN_W'(ONE_P))
    else $error("rotation denominator below one");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_J-1] |-> (dv_rem_r[DQ_STEPS][0] < dv_den_r[DQ_STEPS])
                   && (dv_rem_r[DQ_STEPS][1] < dv_den_r[DQ_STEPS])
                   && (dv_rem_r[DQ_STEPS][2] < dv_den_r[DQ_STEPS]))
    else $error("division remainder not below divisor");

endmodule

`default_nettype wire
